### rtl/sli_pkg.sv
// Shared types and codes for the sorted list insert/pop block.
package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;

    // Input word action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] in_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
        logic [1:0]                status;
        logic [FILL_W-1:0]         fill_count;
    } t_out_word;

    // What every cell does in the current cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     occupied;  // slot index below the fill count
        logic     tail;      // last occupied slot
        logic     at_count;  // first free slot
    } t_cell_ctrl;

endpackage

### rtl/sli_cell.sv
// One slot of the sorted list: holds a value, compares, and trades with its neighbors.
module sli_cell (
    input  logic                                 i_clk,
    input  sli_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [sli_pkg::VALUE_W-1:0]   i_new_value,
    input  logic signed [sli_pkg::VALUE_W-1:0]   i_head_value,
    input  logic                                 i_prev_ge,
    input  logic signed [sli_pkg::VALUE_W-1:0]   i_prev_value,
    input  logic signed [sli_pkg::VALUE_W-1:0]   i_next_value,
    output logic                                 o_ge,
    output logic signed [sli_pkg::VALUE_W-1:0]   o_value
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // stored value sorts at or after the incoming one
    assign o_ge    = i_ctrl.occupied && (r_value >= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_prev_ge) begin
                    n_value = i_prev_value;
                end else if (o_ge || i_ctrl.at_count) begin
                    n_value = i_new_value;
                end
            end
            CELL_SHIFT: begin
                if (i_ctrl.occupied) begin
                    n_value = i_next_value;
                end
            end
            CELL_ROTATE: begin
                if (i_ctrl.tail) begin
                    n_value = i_head_value;
                end else if (i_ctrl.occupied) begin
                    n_value = i_next_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### rtl/sorted_list_insert_pop_top.sv
// Top level of the sorted list: control, fill count and a row of compare-and-shift cells.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------
//  command | in        | start high, busy low      | i_word  (action, in_value)
//  result  | out       | o_strobe, one cycle only  | o_word  (value, last, status,
//          |           |                           |          fill_count)
//
// Insert and pop update the cell row as the command is accepted; their result
// word shows the cycle after the command and busy stays low, so commands may run
// back to back. A dump of N stored values keeps busy high while the row rotates
// one slot per cycle past the head cell, giving one word per cycle; the row is
// back in order when the dump ends. Empty dumps and unused action codes leave
// busy low. Reset (synchronous, active low) clears the fill count and control
// only; slot contents are don't-care until written. The receiver cannot stall.
module sorted_list_insert_pop_top #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sli_pkg::t_in_word  i_word,
    output logic               o_strobe,
    output sli_pkg::t_out_word o_word
);
    import sli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state          r_state,    n_state;
    logic [CW-1:0]   r_count,    n_count;
    logic [CW-1:0]   r_dump_idx, n_dump_idx;
    logic            r_strobe,   n_strobe;
    t_out_word       r_word,     n_word;

    logic            accept;
    logic            full;
    logic            empty;
    logic            dump_last;
    t_cell_op        cell_op;

    logic [CAPACITY-1:0]               cell_ge;
    logic signed [VALUE_W-1:0]         cell_value [CAPACITY];
    logic [CW+FILL_W-1:0]              fill_next_wide;
    logic [CW+FILL_W-1:0]              fill_cur_wide;

    assign accept    = start && !busy;
    assign busy      = (r_state == S_DUMP);
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign dump_last = ((r_dump_idx + CW'(1)) == r_count);

    // fill_count is the stored count modulo 32
    assign fill_next_wide = {{FILL_W{1'b0}}, n_count};
    assign fill_cur_wide  = {{FILL_W{1'b0}}, r_count};

    // Command decode: what the row does this cycle and which word comes out
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dump_idx = r_dump_idx;
        n_strobe   = 1'b0;
        n_word     = r_word;
        cell_op    = CELL_HOLD;

        if (r_state == S_DUMP) begin
            // head cell goes out, row rotates one slot toward the head
            cell_op           = CELL_ROTATE;
            n_strobe          = 1'b1;
            n_word.out_value  = cell_value[0];
            n_word.out_last   = dump_last;
            n_word.status     = ST_OK;
            n_word.fill_count = fill_cur_wide[FILL_W-1:0];
            n_dump_idx        = r_dump_idx + CW'(1);
            if (dump_last) begin
                n_state = S_IDLE;
            end
        end else if (accept) begin
            case (i_word.action)
                ACT_INSERT: begin
                    n_strobe         = 1'b1;
                    n_word.out_value = '0;
                    n_word.out_last  = 1'b1;
                    if (full) begin
                        n_word.status = ST_FULL;
                    end else begin
                        cell_op       = CELL_INSERT;
                        n_count       = r_count + CW'(1);
                        n_word.status = ST_OK;
                    end
                end
                ACT_POP: begin
                    n_strobe        = 1'b1;
                    n_word.out_last = 1'b1;
                    if (empty) begin
                        n_word.out_value = '0;
                        n_word.status    = ST_EMPTY;
                    end else begin
                        cell_op          = CELL_SHIFT;
                        n_count          = r_count - CW'(1);
                        n_word.out_value = cell_value[0];
                        n_word.status    = ST_OK;
                    end
                end
                ACT_DUMP: begin
                    if (empty) begin
                        n_strobe         = 1'b1;
                        n_word.out_value = '0;
                        n_word.out_last  = 1'b1;
                        n_word.status    = ST_EMPTY;
                    end else begin
                        n_state    = S_DUMP;
                        n_dump_idx = '0;
                    end
                end
                default: begin
                    // unused code: no result, nothing changes
                    n_strobe = 1'b0;
                end
            endcase
            n_word.fill_count = fill_next_wide[FILL_W-1:0];
        end
    end

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_ctrl                 ctrl;
        logic                       prev_ge;
        logic signed [VALUE_W-1:0]  prev_value;
        logic signed [VALUE_W-1:0]  next_value;

        assign ctrl.op       = cell_op;
        assign ctrl.occupied = (CW'(g) < r_count);
        assign ctrl.tail     = (CW'(g + 1) == r_count);
        assign ctrl.at_count = (CW'(g) == r_count);

        if (g == 0) begin : g_head
            assign prev_ge    = 1'b0;
            assign prev_value = '0;
        end else begin : g_body
            assign prev_ge    = cell_ge[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign next_value = '0;
        end else begin : g_mid
            assign next_value = cell_value[g+1];
        end

        sli_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_new_value  (i_word.in_value),
            .i_head_value (cell_value[0]),
            .i_prev_ge    (prev_ge),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .o_ge         (cell_ge[g]),
            .o_value      (cell_value[g])
        );
    end

    // State and registered result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dump_idx <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            r_strobe   <= n_strobe;
        end
        r_word <= n_word;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_word.action == ACT_INSERT) && !full
        |=> r_count == ($past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_dump_holds_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> r_count == $past(r_count))
        else $error("fill count moved during dump");

    a_midword_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_word.out_last |-> busy)
        else $error("non-final word outside a dump");

    a_dump_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_word.action == ACT_DUMP) && !empty |=> busy && !o_strobe)
        else $error("dump did not start");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the sorted list insert/pop block.
module testbench;
    import sli_pkg::*;

    localparam int CAP            = 16;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RAND_PER_PHASE = 140;     // three phases plus the table, about 460 words
    localparam int PLAN_ROWS      = 16;

    // Action code the block leaves unused: no result word, list untouched.
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [31:0] VAL_ONES   = 32'hFFFF_FFFF;

    // One row of the directed table. A pinned row carries its result word
    // typed in by hand; the rest are checked against the shadow list.
    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] val;
        int          reps;
        logic        pin;
        t_out_word   pin_word;
    } t_step;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      start    = 1'b0;
    logic      busy;
    t_in_word  i_word   = '0;
    logic      o_strobe;
    t_out_word o_word;

    // Travels alongside the command word so the monitor knows a pinned row.
    logic      pin_en   = 1'b0;
    t_out_word pin_word = '0;

    // Shadow copy of the list: ascending in slots 0..shadow_count-1.
    logic signed [VALUE_W-1:0] shadow_vals [CAP];
    int        shadow_count    = 0;
    t_out_word pending_results [$];
    int        error_count     = 0;
    int        cycle_count     = 0;
    int        sender_idle_pct = 0;
    t_step     plan [PLAN_ROWS];

    always #5 i_clk = ~i_clk;

    sorted_list_insert_pop_top #(
        .CAPACITY (CAP)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // Apply one accepted command word to the shadow list and queue the
    // result words it must produce.
    function automatic void apply_command(t_in_word w);
        int        pos;
        int        i;
        t_out_word r;
        r          = '0;
        r.out_last = 1'b1;
        case (w.action)
            ACT_INSERT: begin
                if (shadow_count >= CAP) begin
                    r.status = ST_FULL;          // dropped, list unchanged
                end else begin
                    // new value goes in front of the first entry >= it,
                    // so equal values end up newest first
                    pos = shadow_count;
                    for (i = shadow_count - 1; i >= 0; i--) begin
                        if (shadow_vals[i] >= w.in_value) pos = i;
                    end
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_vals[pos] = w.in_value;
                    shadow_count++;
                    r.status = ST_OK;
                end
                r.fill_count = FILL_W'(shadow_count);
                pending_results.push_back(r);
            end
            ACT_POP: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_value = shadow_vals[0];
                    for (i = 1; i < shadow_count; i++) begin
                        shadow_vals[i-1] = shadow_vals[i];
                    end
                    shadow_count--;
                    r.status = ST_OK;
                end
                r.fill_count = FILL_W'(shadow_count);
                pending_results.push_back(r);
            end
            ACT_DUMP: begin
                r.fill_count = FILL_W'(shadow_count);
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    // one word per entry, last flag on the final one only
                    for (i = 0; i < shadow_count; i++) begin
                        r.out_value = shadow_vals[i];
                        r.out_last  = (i == shadow_count - 1);
                        r.status    = ST_OK;
                        pending_results.push_back(r);
                    end
                end
            end
            default: begin
                // unused code: no result word
            end
        endcase
    endfunction

    function automatic t_step op_row(logic [1:0] a, logic [31:0] v, int n);
        t_step s;
        s          = '0;
        s.act      = a;
        s.val      = v;
        s.reps     = n;
        return s;
    endfunction

    function automatic t_step fixed_row(logic [1:0] a, logic [31:0] v,
                                        logic [31:0] exp_val, logic [1:0] exp_status,
                                        int exp_fill);
        t_step s;
        s                     = '0;
        s.act                 = a;
        s.val                 = v;
        s.reps                = 1;
        s.pin                 = 1'b1;
        s.pin_word.out_value  = exp_val;
        s.pin_word.out_last   = 1'b1;
        s.pin_word.status     = exp_status;
        s.pin_word.fill_count = FILL_W'(exp_fill);
        return s;
    endfunction

    // Mix of full-range values, a narrow band that forces duplicates, the signed
    // extremes, and zero or all ones.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return 32'(int'($urandom_range(16)) - 8);
            8:             return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default:       return $urandom_range(1) ? 32'h0 : VAL_ONES;
        endcase
    endfunction

    // Present one command word; returns at the edge where it is accepted,
    // with start still high. Random idle cycles go in front of it.
    task automatic send_word(input t_in_word w, input logic pin, input t_out_word pw);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_word   <= w;
        pin_en   <= pin;
        pin_word <= pw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold off the sender until every expected result word is in.
    // The extra edge lets the monitor queue the last accepted word first.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic in well-formed runs: fill-heavy stretches push the list
    // to full, drain-heavy ones take it back to empty. Dumps land at whatever
    // depth the list has. The unused code shows up as noise and does not count.
    task automatic run_random_phase(input int n_items);
        int       sent;
        int       r;
        logic     filling;
        t_in_word w;
        sent    = 0;
        filling = 1'b1;
        while (sent < n_items) begin
            if ($urandom_range(15) == 0) filling = !filling;
            r          = $urandom_range(99);
            w.in_value = pick_value();
            if (r < 3)                        w.action = ACT_UNUSED;
            else if (r < (filling ? 70 : 25)) w.action = ACT_INSERT;
            else if (r < 88)                  w.action = ACT_POP;
            else                              w.action = ACT_DUMP;
            send_word(w, 1'b0, '0);
            if (w.action != ACT_UNUSED) sent++;
        end
    endtask

    // Result checker and acceptance monitor. Everything is sampled at the
    // rising edge, before the block's own updates of that edge land.
    always @(posedge i_clk) begin : monitor
        t_out_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: out_value %0d status %0d",
                       o_word.out_value, o_word.status);
                error_count++;
            end else begin
                exp_w = pending_results.pop_front();
                if (o_word.out_value !== exp_w.out_value) begin
                    $error("out_value: expected %0d, got %0d",
                           exp_w.out_value, o_word.out_value);
                    error_count++;
                end
                if (o_word.out_last !== exp_w.out_last) begin
                    $error("out_last: expected %0d, got %0d",
                           exp_w.out_last, o_word.out_last);
                    error_count++;
                end
                if (o_word.status !== exp_w.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_w.status, o_word.status);
                    error_count++;
                end
                if (o_word.fill_count !== exp_w.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           exp_w.fill_count, o_word.fill_count);
                    error_count++;
                end
            end
        end
        // The result of a word accepted here shows in the following cycle at the
        // earliest, so queueing after the check is safe.
        if (i_rst_n && start && !busy) begin
            apply_command(i_word);
            if (pin_en) begin
                // pinned rows give exactly one word: swap in the typed one
                void'(pending_results.pop_back());
                pending_results.push_back(pin_word);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int       k;
        int       n;
        t_in_word w;

        // Directed table: empty-list errors, unused code, extremes, equal
        // values, a dump, pop of the minimum, fill to capacity, full drop.
        plan = '{
            fixed_row(ACT_POP,    32'h0,        32'h0,   ST_EMPTY, 0),
            fixed_row(ACT_DUMP,   32'h0,        32'h0,   ST_EMPTY, 0),
            op_row   (ACT_UNUSED, VAL_ONES,     1),
            fixed_row(ACT_INSERT, VAL_MAX,      32'h0,   ST_OK,    1),
            fixed_row(ACT_INSERT, VAL_MIN,      32'h0,   ST_OK,    2),
            op_row   (ACT_INSERT, 32'h0,        1),
            op_row   (ACT_INSERT, 32'h0,        1),
            op_row   (ACT_INSERT, VAL_ONES,     1),
            op_row   (ACT_DUMP,   VAL_ONES,     1),
            fixed_row(ACT_POP,    VAL_ONES,     VAL_MIN, ST_OK,    4),
            op_row   (ACT_INSERT, 32'h5555_5555, 6),
            op_row   (ACT_INSERT, 32'hAAAA_AAAA, 6),
            fixed_row(ACT_INSERT, 32'h0000_0123, 32'h0,  ST_FULL,  CAP),
            op_row   (ACT_DUMP,   32'h0,        1),
            op_row   (ACT_POP,    32'h0,        1),
            op_row   (ACT_INSERT, VAL_MAX,      1)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender idles about a third of the cycles
        sender_idle_pct = 32;
        for (k = 0; k < PLAN_ROWS; k++) begin
            for (n = 0; n < plan[k].reps; n++) begin
                w.action   = plan[k].act;
                w.in_value = plan[k].val;
                send_word(w, plan[k].pin, plan[k].pin_word);
            end
        end
        drain_results();

        run_random_phase(RAND_PER_PHASE);
        drain_results();                     // sender holds until all results are in

        // phase 2: heavier idling
        sender_idle_pct = 45;
        run_random_phase(RAND_PER_PHASE);

        // phase 3: back to back
        sender_idle_pct = 0;
        run_random_phase(RAND_PER_PHASE);
        drain_results();

        // room for a stray word after the last expected one
        repeat (CAP + 4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sorted_list_insert_pop_top.f
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_pop_top.sv
dv/testbench.sv
